@@ rtl/ordered_queue_remove_by_key_assert.svh @@
// Assertion macros shared by the ordered queue RTL.
`ifndef ORDERED_QUEUE_REMOVE_BY_KEY_ASSERT_SVH
`define ORDERED_QUEUE_REMOVE_BY_KEY_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define OQRK_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("oqrk: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define OQRK_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("oqrk: next-cycle check failed");

`endif

@@ rtl/oqrk_pkg.sv @@
// Package: sequencer states, operation and status codes, queue status type.
package oqrk_pkg;

    localparam logic [1:0] MODE_APPEND = 2'd0;
    localparam logic [1:0] MODE_REMOVE = 2'd1;
    localparam logic [1:0] MODE_DUMP   = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_MISSING = 2'd2;
    localparam logic [1:0] ST_EMPTY   = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_SHIFT,
        S_DUMP,
        S_REPLY
    } t_state;

    // Occupancy and pop of the output queue, seen by the sequencer.
    typedef struct packed {
        logic [1:0] count;
        logic       pop;
    } t_q_stat;

endpackage

@@ rtl/oqrk_if.sv @@
// Valid/ready channel interfaces for the input and result transactions.
interface oqrk_in_if #(
    parameter int KEY_BITS = 20
);
    logic                valid;
    logic                ready;
    logic [1:0]          mode;
    logic [KEY_BITS-1:0] key;

    modport source (output valid, mode, key, input ready);
    modport sink   (input valid, mode, key, output ready);
endinterface

interface oqrk_out_if #(
    parameter int KEY_BITS = 20
);
    logic                valid;
    logic                ready;
    logic [1:0]          status;
    logic [KEY_BITS-1:0] entry_key;
    logic                last;

    modport source (output valid, status, entry_key, last, input ready);
    modport sink   (input valid, status, entry_key, last, output ready);
endinterface

@@ rtl/oqrk_outq.sv @@
// Two-entry result queue between the sequencer and the output channel.
module oqrk_outq #(
    parameter int KEY_BITS = 20
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    oqrk_out_if.sink          i_push,
    oqrk_out_if.source        o_out,
    output oqrk_pkg::t_q_stat o_stat
);
    import oqrk_pkg::*;

    logic [KEY_BITS-1:0] r_key [2];
    logic [1:0]          r_status [2];
    logic                r_last [2];
    logic                r_wp;
    logic                r_rp;
    logic [1:0]          r_cnt;
    logic                w_push;
    logic                w_pop;

    assign i_push.ready    = (r_cnt != 2'd2);
    assign o_out.valid     = (r_cnt != 2'd0);
    assign o_out.status    = r_status[r_rp];
    assign o_out.entry_key = r_key[r_rp];
    assign o_out.last      = r_last[r_rp];

    assign w_push = i_push.valid && i_push.ready;
    assign w_pop  = o_out.valid && o_out.ready;

    assign o_stat.count = r_cnt;
    assign o_stat.pop   = w_pop;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_key[r_wp]    <= i_push.entry_key;
            r_status[r_wp] <= i_push.status;
            r_last[r_wp]   <= i_push.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            unique case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

@@ rtl/ordered_queue_remove_by_key.sv @@
// Top level: ordered key queue with append, remove-by-key and dump.
//
//  channel | dir | transaction payload              | accepted when
//  --------+-----+----------------------------------+---------------------------
//  i_in    | in  | mode, key                        | i_in.valid && i_in.ready
//  o_out   | out | status, entry_key, last          | o_out.valid && o_out.ready
//
// Append and the empty-queue remove and dump go through accept, then reply.
// Remove reads the entries in order until the key matches, then shifts each later entry
// down one slot and replies, or replies after the last entry on a miss; the single read port serves all reads.
// Dump makes one memory read per entry, each only while the result queue is sure to have room for it.
// Reset clears the entry count and the sequencer state; the key memory is never cleared.
// o_out stalls hold back the sequencer through a two-entry result queue;
// i_in.ready is high only while the sequencer is idle.
`include "ordered_queue_remove_by_key_assert.svh"

module ordered_queue_remove_by_key #(
    parameter int DEPTH    = 64,
    parameter int KEY_BITS = 20
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    oqrk_in_if.sink    i_in,
    oqrk_out_if.source o_out
);
    import oqrk_pkg::*;

    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    // Key storage: one write and one registered read per cycle.
    logic [KEY_BITS-1:0] r_mem [DEPTH];
    logic [KEY_BITS-1:0] r_rd_data;

    // Sequencer state.
    t_state              r_state;
    t_state              n_state;
    logic [CNT_W-1:0]    r_count;   // stored entries
    logic [CNT_W-1:0]    r_idx;     // next address to read
    logic [CNT_W-1:0]    r_chk;     // address whose data sits in r_rd_data
    logic                r_pend;    // r_rd_data holds a fresh read
    logic [KEY_BITS-1:0] r_key;     // key being searched
    logic [1:0]          r_res_status;

    // Memory port controls.
    logic                rd_en;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic [KEY_BITS-1:0] wr_data;

    // Decodes.
    logic                in_acc;
    logic                is_full;
    logic                is_empty;
    logic                more_to_read;
    logic                hit;
    logic                at_tail;
    logic                scan_end;
    logic                dump_credit;
    logic [CNT_W-1:0]    chk_prev;
    logic [CNT_W-1:0]    count_inc;
    logic [2:0]          q_load;
    logic [2:0]          q_room;

    t_q_stat             q_stat;

    oqrk_out_if #(.KEY_BITS(KEY_BITS)) push_if ();

    oqrk_outq #(
        .KEY_BITS (KEY_BITS)
    ) u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push_if),
        .o_out   (o_out),
        .o_stat  (q_stat)
    );

    assign in_acc       = i_in.valid && i_in.ready;
    assign is_full      = (r_count >= CNT_W'(DEPTH));
    assign is_empty     = (r_count == '0);
    assign more_to_read = (r_idx < r_count);
    assign at_tail      = ((r_chk + CNT_W'(1)) == r_count);
    assign hit          = r_pend && (r_rd_data == r_key);
    assign scan_end     = r_pend && !hit && at_tail;
    assign chk_prev     = r_chk - CNT_W'(1);
    assign count_inc    = r_count + CNT_W'(1);

    // Issue a dump read only if its data is sure to find room in the queue.
    assign q_load      = {1'b0, q_stat.count} + {2'b00, r_pend};
    assign q_room      = 3'd1 + {2'b00, q_stat.pop};
    assign dump_credit = (q_load <= q_room);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    unique case (i_in.mode)
                        MODE_APPEND: n_state = S_REPLY;
                        MODE_REMOVE: n_state = is_empty ? S_REPLY : S_SEARCH;
                        MODE_DUMP:   n_state = is_empty ? S_REPLY : S_DUMP;
                        default:     n_state = S_IDLE;
                    endcase
                end
            end
            S_SEARCH: begin
                priority if (hit) begin
                    n_state = S_SHIFT;
                end else if (scan_end) begin
                    n_state = S_REPLY;
                end else begin
                    n_state = S_SEARCH;
                end
            end
            S_SHIFT: begin
                if (!r_pend && !more_to_read) begin
                    n_state = S_REPLY;
                end
            end
            S_DUMP: begin
                if (!r_pend && !more_to_read) begin
                    n_state = S_IDLE;
                end
            end
            S_REPLY: begin
                if (push_if.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control outputs.
    always_comb begin
        i_in.ready        = 1'b0;
        rd_en             = 1'b0;
        wr_en             = 1'b0;
        wr_addr           = r_count[AW-1:0];
        wr_data           = i_in.key;
        push_if.valid     = 1'b0;
        push_if.status    = ST_OK;
        push_if.entry_key = '0;
        push_if.last      = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                i_in.ready = 1'b1;
                wr_en      = in_acc && (i_in.mode == MODE_APPEND) && !is_full;
            end
            S_SEARCH: begin
                rd_en = !hit && more_to_read;
            end
            S_SHIFT: begin
                rd_en   = more_to_read;
                wr_en   = r_pend;
                wr_addr = chk_prev[AW-1:0];
                wr_data = r_rd_data;
            end
            S_DUMP: begin
                rd_en             = more_to_read && dump_credit;
                push_if.valid     = r_pend;
                push_if.entry_key = r_rd_data;
                push_if.last      = at_tail;
            end
            S_REPLY: begin
                push_if.valid  = 1'b1;
                push_if.status = r_res_status;
            end
            default: begin
                i_in.ready = 1'b0;
            end
        endcase
    end

    // Key memory.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[r_idx[AW-1:0]];
        end
    end

    // Datapath registers: search key, read tracking, reply code.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_key  <= i_in.key;
                r_idx  <= '0;
                r_pend <= 1'b0;
                if (in_acc) begin
                    unique case (i_in.mode)
                        MODE_APPEND: r_res_status <= is_full ? ST_FULL : ST_OK;
                        MODE_REMOVE: r_res_status <= ST_MISSING;
                        MODE_DUMP:   r_res_status <= ST_EMPTY;
                        default:     r_res_status <= r_res_status;
                    endcase
                end
            end
            S_SEARCH: begin
                priority if (hit) begin
                    // Start the compaction from the slot after the match.
                    r_idx  <= r_chk + CNT_W'(1);
                    r_pend <= 1'b0;
                end else if (scan_end) begin
                    r_pend       <= 1'b0;
                    r_res_status <= ST_MISSING;
                end else begin
                    r_pend <= rd_en;
                    if (rd_en) begin
                        r_chk <= r_idx;
                        r_idx <= r_idx + CNT_W'(1);
                    end
                end
            end
            S_SHIFT, S_DUMP: begin
                r_pend       <= rd_en;
                r_res_status <= ST_OK;
                if (rd_en) begin
                    r_chk <= r_idx;
                    r_idx <= r_idx + CNT_W'(1);
                end
            end
            default: begin
                r_pend <= 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            priority if (r_state == S_IDLE && wr_en) begin
                r_count <= count_inc;
            end else if (r_state == S_SHIFT && n_state == S_REPLY) begin
                // Compaction done: drop the removed entry.
                r_count <= r_count - CNT_W'(1);
            end else begin
                r_count <= r_count;
            end
        end
    end

    `OQRK_ASSERT_IMP(a_dump_room, i_clk, i_rst_n, (r_state == S_DUMP) && r_pend, push_if.ready)
    `OQRK_ASSERT_IMP(a_count_max, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(DEPTH))
    `OQRK_ASSERT_IMP(a_read_in_range, i_clk, i_rst_n, rd_en, r_idx < r_count)
    `OQRK_ASSERT_NXT(a_append_grows, i_clk, i_rst_n, in_acc && wr_en, r_count == $past(count_inc))

endmodule

@@ bench/oqrk_checker.sv @@
// Checker for the ordered key queue: tracks queue contents, predicts replies and compares them.
module oqrk_checker #(
    parameter int DEPTH    = 64,
    parameter int KEY_BITS = 20
) (
    input  logic i_clk,
    input  logic i_rst_n,
    oqrk_in_if   i_in_ch,
    oqrk_out_if  i_out_ch,
    input  logic i_done,
    output int   o_fail_count,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import oqrk_pkg::*;

    typedef struct packed {
        logic [1:0]          status;
        logic [KEY_BITS-1:0] entry_key;
        logic                last;
    } t_queue_reply;

    logic [KEY_BITS-1:0] held_keys[$];
    t_queue_reply        awaited_replies[$];
    int                  fail_count = 0;
    int                  reply_index = 0;
    bit                  leftovers_checked = 1'b0;

    assign o_fail_count = fail_count;

    task automatic report_mismatch(input string what);
        fail_count++;
        $display("%0t ns: MISMATCH %s", $time, what);
    endtask

    task automatic await_reply(input logic [1:0] status, input logic [KEY_BITS-1:0] key,
                               input logic last);
        t_queue_reply r;
        r.status    = status;
        r.entry_key = key;
        r.last      = last;
        awaited_replies.push_back(r);
    endtask

    // Apply one accepted command to the tracked queue and queue up its replies.
    task automatic predict_queue_op(input logic [1:0] mode, input logic [KEY_BITS-1:0] key);
        int hit;
        hit = -1;
        case (mode)
            MODE_APPEND: begin
                if (held_keys.size() >= DEPTH) begin
                    await_reply(ST_FULL, '0, 1'b1);
                end else begin
                    held_keys.push_back(key);
                    await_reply(ST_OK, '0, 1'b1);
                end
            end
            MODE_REMOVE: begin
                foreach (held_keys[i]) begin
                    if (hit < 0 && held_keys[i] == key) hit = i;
                end
                if (hit < 0) begin
                    await_reply(ST_MISSING, '0, 1'b1);
                end else begin
                    held_keys.delete(hit);
                    await_reply(ST_OK, '0, 1'b1);
                end
            end
            MODE_DUMP: begin
                if (held_keys.size() == 0) begin
                    await_reply(ST_EMPTY, '0, 1'b1);
                end else begin
                    foreach (held_keys[i]) begin
                        await_reply(ST_OK, held_keys[i], i == held_keys.size() - 1);
                    end
                end
            end
            default: ;
        endcase
    endtask

    task automatic check_reply();
        t_queue_reply want;
        if (awaited_replies.size() == 0) begin
            report_mismatch($sformatf("reply %0d arrived with nothing outstanding", reply_index));
        end else begin
            want = awaited_replies.pop_front();
            if (i_out_ch.status !== want.status)
                report_mismatch($sformatf("reply %0d status got %0d want %0d",
                                          reply_index, i_out_ch.status, want.status));
            if (i_out_ch.entry_key !== want.entry_key)
                report_mismatch($sformatf("reply %0d entry_key got %h want %h",
                                          reply_index, i_out_ch.entry_key, want.entry_key));
            if (i_out_ch.last !== want.last)
                report_mismatch($sformatf("reply %0d last got %b want %b",
                                          reply_index, i_out_ch.last, want.last));
        end
        reply_index++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_out_ch.valid && i_out_ch.ready) check_reply();
            if (i_in_ch.valid && i_in_ch.ready) predict_queue_op(i_in_ch.mode, i_in_ch.key);
            if (i_done && !leftovers_checked) begin
                leftovers_checked = 1'b1;
                if (awaited_replies.size() != 0)
                    report_mismatch($sformatf("%0d replies never arrived",
                                              awaited_replies.size()));
            end
        end
        o_pending = awaited_replies.size();
    end

endmodule

@@ bench/tb_top.sv @@
// Testbench top: clock, reset, command stimulus, reply back-pressure and verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import oqrk_pkg::*;

    localparam int DEPTH            = 64;
    localparam int KEY_BITS         = 20;
    localparam int CLK_PERIOD       = 12;
    localparam int RESET_CYCLES     = 6;
    localparam int RANDOM_ITEMS     = 390;
    // Long receiver hold-off partway in, calm traffic over the final stretch.
    localparam int HOLD_AT          = 150;
    localparam int CALM_AFTER       = 360;
    localparam int LONG_HOLD_CYCLES = 300;
    // The settle wait covers a remove over a full queue.
    localparam int SETTLE_CYCLES    = 2 * DEPTH + 8;
    localparam int DRAIN_LIMIT      = 50000;
    localparam int WATCHDOG_CYCLES  = 1000000;

    // Mode 3 is not a command; the block must swallow it without a reply.
    localparam logic [1:0]          MODE_UNUSED  = 2'd3;
    localparam logic [KEY_BITS-1:0] KEY_ALL_ONES = '1;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic check_done;
    int   fail_count;
    int   replies_pending;

    // Stimulus state; calm and hold_req are shared with the reply-side process.
    bit   calm;
    bit   hold_req;
    int   gap_odds;
    int   counted_items;
    int   random_base;

    // Keys the queue should hold, used to pick meaningful remove keys and to bound the fill and drain loops.
    logic [KEY_BITS-1:0] queued_keys[$];
    // Small per-phase key set so duplicates and repeat removes show up.
    logic [KEY_BITS-1:0] key_pool[8];

    oqrk_in_if  #(.KEY_BITS(KEY_BITS)) in_ch();
    oqrk_out_if #(.KEY_BITS(KEY_BITS)) out_ch();

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    ordered_queue_remove_by_key #(
        .DEPTH   (DEPTH),
        .KEY_BITS(KEY_BITS)
    ) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    oqrk_checker #(
        .DEPTH   (DEPTH),
        .KEY_BITS(KEY_BITS)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_ch     (in_ch),
        .i_out_ch    (out_ch),
        .i_done      (check_done),
        .o_fail_count(fail_count),
        .o_pending   (replies_pending)
    );

    // Mostly pool keys for collisions, sometimes a raw key to toggle every bit.
    function automatic logic [KEY_BITS-1:0] pick_key();
        if ($urandom_range(0, 3) == 0) return KEY_BITS'($urandom);
        return key_pool[$urandom_range(0, 7)];
    endfunction

    // Pick a stored key with the given odds, else a key that may well be absent.
    function automatic logic [KEY_BITS-1:0] pick_remove_key(input int hit_pct);
        if (queued_keys.size() != 0 && $urandom_range(1, 100) <= hit_pct)
            return queued_keys[$urandom_range(0, queued_keys.size() - 1)];
        return pick_key();
    endfunction

    // Offer one command transaction and hold it until the block takes it.
    task automatic send_op(input logic [1:0] mode, input logic [KEY_BITS-1:0] key);
        int hit;
        int n;
        hit = -1;
        // Drop valid for a short burst now and then, unless in the calm stretch.
        if (!calm && gap_odds != 0 && $urandom_range(1, 100) <= gap_odds) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.mode  <= mode;
        in_ch.key   <= key;
        do @(posedge i_clk); while (!in_ch.ready);

        // Advance the key tracking the same way the queue should move.
        case (mode)
            MODE_APPEND: begin
                if (queued_keys.size() < DEPTH) queued_keys.push_back(key);
            end
            MODE_REMOVE: begin
                foreach (queued_keys[i]) begin
                    if (hit < 0 && queued_keys[i] == key) hit = i;
                end
                if (hit >= 0) queued_keys.delete(hit);
            end
            default: ;
        endcase

        if (mode != MODE_UNUSED) counted_items++;
        if (random_base >= 0) begin
            n = counted_items - random_base;
            if (n == HOLD_AT) hold_req = 1'b1;
            if (n >= CALM_AFTER) calm = 1'b1;
        end
    endtask

    // Reply side: random ready bursts, quiet stretches, and one long hold-off.
    initial begin : reply_ready
        int stall_odds;
        int span;
        int n;
        stall_odds = 0;
        span       = 0;
        forever begin
            if (span <= 0) begin
                case ($urandom_range(0, 2))
                    0:       stall_odds = 0;
                    1:       stall_odds = 15;
                    default: stall_odds = 40;
                endcase
                span = 64;
            end
            if (hold_req) begin
                // Hold ready low long enough for the block to back up into its input.
                out_ch.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (!calm && stall_odds != 0 && $urandom_range(1, 100) <= stall_odds) begin
                out_ch.ready <= 1'b0;
                n = $urandom_range(1, 3);
                repeat (n) @(posedge i_clk);
                span -= n;
            end else begin
                out_ch.ready <= 1'b1;
                @(posedge i_clk);
                span--;
            end
        end
    end

    initial begin : stimulus
        int  r;
        int  waited;
        bit  first_phase;
        i_rst_n       <= 1'b0;
        in_ch.valid   <= 1'b0;
        in_ch.mode    <= MODE_APPEND;
        in_ch.key     <= '0;
        check_done    <= 1'b0;
        calm          = 1'b0;
        hold_req      = 1'b0;
        gap_odds      = 0;
        counted_items = 0;
        random_base   = -1;
        first_phase   = 1'b1;
        foreach (key_pool[i]) key_pool[i] = '0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty-queue cases, key extremes, duplicates, head/middle/tail removes.
        gap_odds = 20;
        send_op(MODE_DUMP,    '0);
        send_op(MODE_REMOVE,  KEY_ALL_ONES);
        send_op(MODE_APPEND,  '0);
        send_op(MODE_APPEND,  KEY_ALL_ONES);
        send_op(MODE_APPEND,  '0);
        send_op(MODE_APPEND,  20'hAAAAA);
        send_op(MODE_APPEND,  20'h55555);
        send_op(MODE_DUMP,    KEY_ALL_ONES);
        send_op(MODE_REMOVE,  '0);
        send_op(MODE_REMOVE,  20'h55555);
        send_op(MODE_REMOVE,  20'h12345);
        send_op(MODE_UNUSED,  KEY_ALL_ONES);
        send_op(MODE_DUMP,    '0);
        send_op(MODE_REMOVE,  '0);
        send_op(MODE_DUMP,    '0);
        send_op(MODE_REMOVE,  KEY_ALL_ONES);
        send_op(MODE_REMOVE,  20'hAAAAA);
        send_op(MODE_DUMP,    '0);
        send_op(MODE_APPEND,  KEY_ALL_ONES);
        send_op(MODE_REMOVE,  KEY_ALL_ONES);

        // Random: phases of well-formed traffic with random keys, plus some noise.
        random_base = counted_items;
        while (counted_items - random_base < RANDOM_ITEMS) begin
            foreach (key_pool[i]) key_pool[i] = KEY_BITS'($urandom);
            case ($urandom_range(0, 2))
                0:       gap_odds = 0;
                1:       gap_odds = 15;
                default: gap_odds = 40;
            endcase
            r = first_phase ? 0 : $urandom_range(0, 9);
            first_phase = 1'b0;
            case (r)
                0, 1: begin
                    // Fill to capacity, push past it, then read the whole queue back.
                    while (queued_keys.size() < DEPTH) send_op(MODE_APPEND, pick_key());
                    repeat ($urandom_range(1, 2)) send_op(MODE_APPEND, pick_key());
                    send_op(MODE_DUMP, pick_key());
                end
                6, 7: begin
                    // Drain in random order with the odd miss, then dump the empty queue.
                    while (queued_keys.size() != 0) send_op(MODE_REMOVE, pick_remove_key(90));
                    send_op(MODE_DUMP, pick_key());
                end
                8: begin
                    // Noise: raw modes and raw keys, the unused mode included.
                    repeat (8) send_op(2'($urandom), KEY_BITS'($urandom));
                end
                default: begin
                    // Mixed traffic around whatever occupancy the queue has now.
                    repeat (20) begin
                        r = $urandom_range(0, 99);
                        if (r < 45)      send_op(MODE_APPEND, pick_key());
                        else if (r < 82) send_op(MODE_REMOVE, pick_remove_key(80));
                        else if (r < 96) send_op(MODE_DUMP, pick_key());
                        else             send_op(MODE_UNUSED, pick_key());
                    end
                end
            endcase
        end

        in_ch.valid <= 1'b0;
        @(posedge i_clk);

        // Wait out the outstanding replies, then let a dropped command settle too.
        waited = 0;
        while (replies_pending != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        check_done <= 1'b1;
        repeat (3) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin : watchdog
        #(CLK_PERIOD * WATCHDOG_CYCLES);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/oqrk_pkg.sv
rtl/oqrk_if.sv
rtl/oqrk_outq.sv
rtl/ordered_queue_remove_by_key.sv
bench/oqrk_checker.sv
bench/tb_top.sv
